// ===== rtl/tsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_pkg: shared types for the timer slot pool
// Command codes, controller states and the command and status groups that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package tsp_pkg;

   // request payload layout
   localparam int DUR_W      = 32;
   localparam int ID_W       = 6;
   localparam int NOW_W      = 32;
   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 16;

   // slots examined per search cycle
   localparam int GROUP_W    = 32;
   localparam int GROUP_LOG  = 5;

   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_RESTART = 2'd1,
      OP_CHECK   = 2'd2,
      OP_STOP    = 2'd3
   } tsp_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SEARCH,
      ST_READ,
      ST_EXEC,
      ST_DONE
   } tsp_state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic dispatch;
      logic search_step;
      logic mem_read;
      logic exec;
      logic load_rsp;
   } tsp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_start;
      logic is_stop;
      logic id_skip;
      logic grp_hit;
      logic grp_last;
   } tsp_status_type;

endpackage

// ===== rtl/timer_slot_pool.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_slot_pool: pool of timer slots with start, restart, check and stop
// Each slot holds a duration and a deadline in small memories; requests carry
// the current tick count and return one response each.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. Restart and check step through
// dispatch, memory read, execute and response. Start steps through dispatch,
// the free-slot scan, execute and response; the scan looks at one group of 32
// slots after another until it finds a free slot, and a start that finds every
// slot busy goes from the scan straight to response. Stop skips the memory
// read, and a restart, check or stop with id 0 or an id above SLOT_COUNT goes
// from dispatch straight to response. These steps are set by the single-port
// slot memories and the free-slot scan, which examines 32 slots per cycle.
// The response sits in its own register, so a new request is taken while the
// previous response still waits; that request then holds in its response
// step until the waiting response is taken.
module timer_slot_pool import tsp_pkg::*; #(
   parameter int SLOT_COUNT = 32,
   parameter int TICK_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] duration_ticks, [37:32] slot_id, [69:38] now_ticks, [71:70] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] operation
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [5:0] granted_id, [6] pool_full, [7] expired, [8] bad_id, [15:9] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   tsp_cmd_type    cmd;
   tsp_status_type status;

   // sequencer
   tsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // slot storage and arithmetic
   tsp_datapath #(
      .SLOT_COUNT (SLOT_COUNT),
      .TICK_WIDTH (TICK_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== rtl/tsp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_datapath: slot storage and per-request arithmetic
// Holds the request, the duration and deadline memories with their valid
// bits, the free-slot scan, the deadline adder and the response register.
// ----------------------------------------------------------------------------
module tsp_datapath import tsp_pkg::*; #(
   parameter int SLOT_COUNT = 32,
   parameter int TICK_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tsp_cmd_type           cmd,
   output tsp_status_type        status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int NUM_GROUPS = (SLOT_COUNT + GROUP_W - 1) / GROUP_W;
   localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int SCAN_W     = GRP_W + GROUP_LOG;
   localparam int SUM_W      = (TICK_WIDTH > NOW_W) ? TICK_WIDTH : NOW_W;
   localparam logic [8:0]       SLOT_COUNT_W = 9'(SLOT_COUNT);
   localparam logic [GRP_W-1:0] LAST_GRP     = GRP_W'(NUM_GROUPS - 1);

   // request register
   tsp_op_type       op_ff;
   logic [DUR_W-1:0] dur_ff;
   logic [ID_W-1:0]  id_ff;
   logic [NOW_W-1:0] now_ff;

   // slot state
   logic [SLOT_COUNT-1:0] du_valid_ff, du_valid_in;
   logic [SLOT_COUNT-1:0] dl_valid_ff, dl_valid_in;
   logic [DUR_W-1:0]      dur_mem [SLOT_COUNT];
   logic [TICK_WIDTH-1:0] dl_mem  [SLOT_COUNT];
   logic [DUR_W-1:0]      rd_dur_ff;
   logic [TICK_WIDTH-1:0] rd_dl_ff;

   // working registers
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [GRP_W-1:0]  grp_ff, grp_in;
   logic [ID_W-1:0]   granted_ff, granted_in;
   logic              full_ff, full_in;
   logic              expired_ff, expired_in;
   logic              bad_ff, bad_in;
   logic [RSP_DATA_W-1:0] out_ff;

   logic                      id_over;
   logic                      id_zero;
   logic [8:0]                id_m1;
   logic [NUM_GROUPS*GROUP_W-1:0] busy_pad;
   logic [GROUP_W-1:0]        grp_bits;
   logic [GROUP_LOG-1:0]      hit_pos;
   logic                      grp_hit;
   logic [SCAN_W-1:0]         found_idx;
   logic [8:0]                found_id;
   logic [DUR_W-1:0]          dur_operand;
   logic [SUM_W-1:0]          sum_wide;
   logic [SUM_W-1:0]          now_wide;
   logic [TICK_WIDTH-1:0]     now_t;
   logic [TICK_WIDTH-1:0]     new_deadline;
   logic [TICK_WIDTH-1:0]     dl_eff;
   logic                      reached;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= tsp_op_type'(req_tuser);
         dur_ff <= req_tdata[DUR_W-1:0];
         id_ff  <= req_tdata[DUR_W +: ID_W];
         now_ff <= req_tdata[DUR_W+ID_W +: NOW_W];
      end
   end

   // id decode
   assign id_zero = (id_ff == '0);
   assign id_over = ({3'b000, id_ff} > SLOT_COUNT_W);
   assign id_m1   = {3'b000, id_ff} - 9'd1;

   // free-slot scan, one group of slots per cycle
   always_comb begin
      busy_pad = '1;
      busy_pad[SLOT_COUNT-1:0] = du_valid_ff;
   end
   assign grp_bits = busy_pad[grp_ff*GROUP_W +: GROUP_W];

   always_comb begin
      hit_pos = '0;
      for (int i = GROUP_W - 1; i >= 0; i--) begin
         if (!grp_bits[i]) begin
            hit_pos = GROUP_LOG'(i);
         end
      end
   end
   assign grp_hit   = ~&grp_bits;
   assign found_idx = {grp_ff, hit_pos};
   assign found_id  = 9'(found_idx) + 9'd1;

   // deadline arithmetic
   assign now_wide     = SUM_W'(now_ff);
   assign now_t        = now_wide[TICK_WIDTH-1:0];
   assign dur_operand  = (op_ff == OP_START) ? dur_ff
                                              : (du_valid_ff[idx_ff] ? rd_dur_ff : '0);
   assign sum_wide     = now_wide + SUM_W'(dur_operand);
   assign new_deadline = sum_wide[TICK_WIDTH-1:0];
   assign dl_eff       = dl_valid_ff[idx_ff] ? rd_dl_ff : '0;
   assign reached      = (now_t >= dl_eff);

   // working register next values
   always_comb begin
      idx_in     = idx_ff;
      grp_in     = grp_ff;
      granted_in = granted_ff;
      full_in    = full_ff;
      expired_in = expired_ff;
      bad_in     = bad_ff;
      if (cmd.capture) begin
         granted_in = '0;
         full_in    = 1'b0;
         expired_in = 1'b0;
         bad_in     = 1'b0;
      end
      if (cmd.dispatch) begin
         idx_in = id_m1[SLOT_W-1:0];
         grp_in = '0;
         if (op_ff != OP_START) begin
            if (id_over) begin
               bad_in = 1'b1;
            end else if (id_zero && (op_ff == OP_CHECK)) begin
               expired_in = 1'b1;
            end
         end
      end
      if (cmd.search_step) begin
         if (grp_hit) begin
            idx_in     = found_idx[SLOT_W-1:0];
            granted_in = found_id[ID_W-1:0];
         end else if (grp_ff == LAST_GRP) begin
            full_in = 1'b1;
         end else begin
            grp_in = grp_ff + GRP_W'(1);
         end
      end
      if (cmd.exec && (op_ff == OP_CHECK) && reached) begin
         expired_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      grp_ff     <= grp_in;
      granted_ff <= granted_in;
      full_ff    <= full_in;
      expired_ff <= expired_in;
      bad_ff     <= bad_in;
   end

   // valid bits: a cleared bit reads as the zero reset value
   always_comb begin
      du_valid_in = du_valid_ff;
      dl_valid_in = dl_valid_ff;
      if (cmd.exec) begin
         unique case (op_ff)
            OP_START: begin
               du_valid_in[idx_ff] = (dur_ff != '0);
               dl_valid_in[idx_ff] = 1'b1;
            end
            OP_RESTART: begin
               dl_valid_in[idx_ff] = 1'b1;
            end
            OP_CHECK: begin
               if (reached) begin
                  du_valid_in[idx_ff] = 1'b0;
                  dl_valid_in[idx_ff] = 1'b0;
               end
            end
            OP_STOP: begin
               du_valid_in[idx_ff] = 1'b0;
               dl_valid_in[idx_ff] = 1'b0;
            end
            default: begin
               du_valid_in = du_valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         du_valid_ff <= '0;
         dl_valid_ff <= '0;
      end else begin
         du_valid_ff <= du_valid_in;
         dl_valid_ff <= dl_valid_in;
      end
   end

   // duration memory
   always_ff @(posedge clock) begin
      if (cmd.exec && (op_ff == OP_START) && (dur_ff != '0)) begin
         dur_mem[idx_ff] <= dur_ff;
      end
      if (cmd.mem_read) begin
         rd_dur_ff <= dur_mem[idx_ff];
      end
   end

   // deadline memory
   always_ff @(posedge clock) begin
      if (cmd.exec && ((op_ff == OP_START) || (op_ff == OP_RESTART))) begin
         dl_mem[idx_ff] <= new_deadline;
      end
      if (cmd.mem_read) begin
         rd_dl_ff <= dl_mem[idx_ff];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         out_ff <= {7'b0000000, bad_ff, expired_ff, full_ff, granted_ff};
      end
   end
   assign rsp_tdata = out_ff;

   // status to controller
   assign status.is_start = (op_ff == OP_START);
   assign status.is_stop  = (op_ff == OP_STOP);
   assign status.id_skip  = id_over || id_zero;
   assign status.grp_hit  = grp_hit;
   assign status.grp_last = (grp_ff == LAST_GRP);

`ifndef SYNTHESIS
   // a granted slot is always one that was free
   assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && (op_ff == OP_START)) |-> !du_valid_ff[idx_ff])
      else $error("start writes a busy slot");
   // a stop always leaves the slot free
   assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && (op_ff == OP_STOP)) |=> !du_valid_ff[$past(idx_ff)])
      else $error("stopped slot still busy");
`endif

endmodule

// ===== rtl/tsp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_ctrl: request sequencer for the timer slot pool
// Steps requests through dispatch, scan or read, execute and response as
// needed, and owns the request ready and response valid handshake.
// ----------------------------------------------------------------------------
module tsp_ctrl import tsp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  tsp_status_type status,
   output tsp_cmd_type    cmd
);

   tsp_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            priority if (status.is_start) begin
               state_in = ST_SEARCH;
            end else if (status.id_skip) begin
               state_in = ST_DONE;
            end else if (status.is_stop) begin
               state_in = ST_EXEC;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_SEARCH: begin
            priority if (status.grp_hit) begin
               state_in = ST_EXEC;
            end else if (status.grp_last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:     cmd.capture     = req_tvalid;
         ST_DISPATCH: cmd.dispatch    = 1'b1;
         ST_SEARCH:   cmd.search_step = 1'b1;
         ST_READ:     cmd.mem_read    = 1'b1;
         ST_EXEC:     cmd.exec        = 1'b1;
         ST_DONE:     cmd.load_rsp    = rsp_free;
         default:     cmd             = '0;
      endcase
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   // an accepted request always goes to dispatch
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_DISPATCH))
      else $error("accepted request not dispatched");
   // a response is never loaded over one still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwritten");
   // a scan that misses the last group ends in a response
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SEARCH) && !status.grp_hit && status.grp_last)
         |=> (state_ff == ST_DONE))
      else $error("scan ran past last group");
`endif

endmodule

// ===== verif/tb_timer_slot_pool.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timer_slot_pool: self-checking bench for the timer slot pool
// A short directed sequence walks through grant, re-arm, expiry, stop, id
// zero, out-of-range ids and deadline wrap. Random rounds then fill, churn and
// drain the pool with a moving tick count. Every accepted request is run
// through a local slot model and each response is compared field by field.
// Both stream sides idle in random bursts, and the response side holds off
// for a long stretch once so that the request side backs up.
// ----------------------------------------------------------------------------
module tb_timer_slot_pool import tsp_pkg::*;;

   localparam int SLOTS        = 32;
   localparam int CLK_HALF     = 5;
   localparam int RANDOM_ITEMS = 1250;
   localparam int QUIET_TAIL   = 120;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      tsp_op_type  op;
      logic [31:0] dur;
      logic [5:0]  id;
      logic [31:0] now;
   } timer_cmd_type;

   typedef struct packed {
      logic [6:0] pad;
      logic       bad;
      logic       expired;
      logic       full;
      logic [5:0] granted;
   } timer_rsp_type;

   typedef enum int {
      GEN_FILL,
      GEN_CHURN,
      GEN_DRAIN
   } gen_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // local copy of the slot memories
   logic [31:0] slot_len [SLOTS];
   logic [31:0] slot_due [SLOTS];

   timer_cmd_type cmd_queue[$];
   timer_rsp_type rsp_expected[$];
   timer_cmd_type driven_cmd;

   logic [31:0] gen_now;
   int          total_cmds     = 0;
   int          accepted_count = 0;
   int          rsp_count      = 0;
   int          mismatch_count = 0;
   int          req_gap        = 0;
   int          rsp_gap        = 0;
   logic        req_taken      = 1'b0;
   logic        rsp_hold       = 1'b0;
   logic        quiet;

   assign quiet = (accepted_count + QUIET_TAIL >= total_cmds);

   timer_slot_pool #(
      .SLOT_COUNT(SLOTS),
      .TICK_WIDTH(32)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock
   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // slot model: apply one request and return its response
   function automatic timer_rsp_type apply_timer_cmd(input timer_cmd_type c);
      timer_rsp_type r;
      logic          found;
      int            slot;
      r     = '0;
      found = 1'b0;
      if (c.op == OP_START) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (!found && slot_len[i] == 32'd0) begin
               slot_len[i] = c.dur;
               slot_due[i] = c.now + c.dur;
               r.granted   = 6'(i + 1);
               found       = 1'b1;
            end
         end
         r.full = !found;
      end else if (c.id > SLOTS) begin
         r.bad = 1'b1;
      end else if (c.id == 6'd0) begin
         r.expired = (c.op == OP_CHECK);
      end else begin
         slot = int'(c.id) - 1;
         case (c.op)
            OP_RESTART: begin
               slot_due[slot] = c.now + slot_len[slot];
            end
            OP_CHECK: begin
               if (c.now >= slot_due[slot]) begin
                  slot_len[slot] = '0;
                  slot_due[slot] = '0;
                  r.expired      = 1'b1;
               end
            end
            default: begin
               slot_len[slot] = '0;
               slot_due[slot] = '0;
            end
         endcase
      end
      return r;
   endfunction

   task automatic push_cmd(input tsp_op_type op, input logic [31:0] dur,
                           input logic [5:0] id, input logic [31:0] now);
      timer_cmd_type c;
      c.op  = op;
      c.dur = dur;
      c.id  = id;
      c.now = now;
      cmd_queue.push_back(c);
   endtask

   // random request with a tick count that mostly moves forward
   function automatic timer_cmd_type random_cmd(input gen_mode_type mode);
      timer_cmd_type c;
      int            pick;
      int            kind;
      gen_now = gen_now + 32'($urandom_range(0, 40));
      if ($urandom_range(0, 49) == 0) gen_now = $urandom;
      pick = $urandom_range(0, 99);
      // noise: every field fully random
      if (pick < 8) begin
         c.op  = tsp_op_type'($urandom_range(0, 3));
         c.dur = $urandom;
         c.id  = 6'($urandom_range(0, 63));
         c.now = $urandom;
         return c;
      end
      case (mode)
         GEN_FILL:  c.op = (pick < 90) ? OP_START : (pick < 95) ? OP_CHECK : OP_RESTART;
         GEN_DRAIN: c.op = (pick < 20) ? OP_START : (pick < 70) ? OP_CHECK :
                           (pick < 85) ? OP_STOP : OP_RESTART;
         default:   c.op = tsp_op_type'($urandom_range(0, 3));
      endcase
      kind = $urandom_range(0, 9);
      if (kind < 7)       c.dur = 32'($urandom_range(1, 300));
      else if (kind == 7) c.dur = '0;
      else if (kind == 8) c.dur = $urandom;
      else                c.dur = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
      kind = $urandom_range(0, 99);
      if (kind < 85)      c.id = 6'($urandom_range(1, SLOTS));
      else if (kind < 92) c.id = '0;
      else                c.id = 6'($urandom_range(SLOTS + 1, 63));
      c.now = gen_now;
      return c;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("mismatch on response %0d: %s expected %0h got %0h",
               rsp_count, what, want, got);
      mismatch_count++;
   endtask

   // request driver: changes on the falling edge
   always @(negedge clock) begin : req_driver
      timer_cmd_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // request still waiting, hold it
      end else if (req_gap > 0) begin
         req_gap    <= req_gap - 1;
         req_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         req_gap    <= $urandom_range(0, 18);
         req_tvalid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
         nxt         = cmd_queue.pop_front();
         driven_cmd <= nxt;
         req_tvalid <= 1'b1;
         req_tdata  <= {2'b00, nxt.now, nxt.id, nxt.dur};
         req_tuser  <= nxt.op;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // response ready with random stalls and the long hold-off
   always @(negedge clock) begin
      if (reset || rsp_hold) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap    <= rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_gap    <= $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: predict on accepted requests, compare accepted responses
   always @(posedge clock) begin : stream_monitor
      timer_rsp_type want;
      timer_rsp_type got;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            rsp_expected.push_back(apply_timer_cmd(driven_cmd));
            accepted_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (rsp_expected.size() == 0) begin
               report_mismatch("response with no request pending", 32'd0, 32'(got));
            end else begin
               want = rsp_expected.pop_front();
               if (got.granted !== want.granted)
                  report_mismatch("granted_id", 32'(want.granted), 32'(got.granted));
               if (got.full !== want.full)
                  report_mismatch("pool_full", 32'(want.full), 32'(got.full));
               if (got.expired !== want.expired)
                  report_mismatch("expired", 32'(want.expired), 32'(got.expired));
               if (got.bad !== want.bad)
                  report_mismatch("bad_id", 32'(want.bad), 32'(got.bad));
               if (got.pad !== want.pad)
                  report_mismatch("padding", 32'(want.pad), 32'(got.pad));
            end
            rsp_count++;
         end
      end
   end

   // long response hold-off so the pool backs up its request side
   initial begin
      wait (accepted_count >= HOLD_AT);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // stimulus and end of run
   initial begin : stimulus
      int            counted;
      int            round_len;
      gen_mode_type  mode;
      timer_cmd_type c;
      for (int i = 0; i < SLOTS; i++) begin
         slot_len[i] = '0;
         slot_due[i] = '0;
      end
      gen_now = '0;

      // zero-duration grant keeps the slot free
      push_cmd(OP_START,   32'd0,          6'd0,  32'hFFFF_FFFF);
      push_cmd(OP_CHECK,   32'd0,          6'd1,  32'hFFFF_FFFE);
      // deadline wraps past the top of the tick range
      push_cmd(OP_START,   32'hFFFF_FFFF,  6'd63, 32'hFFFF_FFFF);
      push_cmd(OP_START,   32'd5,          6'd0,  32'd100);
      push_cmd(OP_CHECK,   32'd0,          6'd2,  32'd104);
      push_cmd(OP_RESTART, 32'd0,          6'd2,  32'd200);
      push_cmd(OP_CHECK,   32'd0,          6'd2,  32'd205);
      // id zero
      push_cmd(OP_CHECK,   32'd0,          6'd0,  32'd0);
      push_cmd(OP_RESTART, 32'd0,          6'd0,  32'd9);
      push_cmd(OP_STOP,    32'd0,          6'd0,  32'd9);
      // ids past the pool
      push_cmd(OP_CHECK,   32'd0,          6'd33, 32'hFFFF_FFFF);
      push_cmd(OP_RESTART, 32'd0,          6'd63, 32'd1);
      push_cmd(OP_STOP,    32'd0,          6'd40, 32'd1);
      // re-arm and check of free slots
      push_cmd(OP_RESTART, 32'd0,          6'd5,  32'd77);
      push_cmd(OP_CHECK,   32'd0,          6'd5,  32'd76);
      push_cmd(OP_CHECK,   32'd0,          6'd6,  32'd0);
      // stop then check
      push_cmd(OP_STOP,    32'd0,          6'd1,  32'd0);
      push_cmd(OP_CHECK,   32'd0,          6'd1,  32'd0);
      push_cmd(OP_START,   32'd1,          6'd0,  32'hFFFF_FFFF);
      push_cmd(OP_CHECK,   32'd0,          6'd1,  32'd0);
      push_cmd(OP_RESTART, 32'd0,          6'd32, 32'd9);
      push_cmd(OP_CHECK,   32'd0,          6'd32, 32'd9);

      // random rounds
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0:       mode = GEN_FILL;
            1:       mode = GEN_DRAIN;
            default: mode = GEN_CHURN;
         endcase
         round_len = (mode == GEN_FILL) ? $urandom_range(40, 60) : $urandom_range(20, 60);
         repeat (round_len) begin
            c = random_cmd(mode);
            cmd_queue.push_back(c);
            counted++;
         end
      end
      total_cmds = cmd_queue.size();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (accepted_count == total_cmds);
      wait (rsp_expected.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (rsp_expected.size() != 0)
         report_mismatch("responses never arrived", 32'd0, 32'(rsp_expected.size()));
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tsp_pkg.sv
rtl/tsp_datapath.sv
rtl/tsp_ctrl.sv
rtl/timer_slot_pool.sv
verif/tb_timer_slot_pool.sv
